// ===== design/dls_pkg.sv =====
package dls_pkg;

    // Default number of fraction bits of the level; 1.0 is 2**LEVEL_FRAC_BITS.
    localparam int DLS_LEVEL_FRAC_BITS = 30;

    // Coefficients are unsigned Q16.
    localparam int COEF_W    = 17;
    localparam int COEF_FRAC = 16;
    localparam int STEP_W    = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 17;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKING = 2'd3;

    // Smoothing curves.
    localparam logic [1:0] MODE_LINEAR  = 2'd0;
    localparam logic [1:0] MODE_HALF_SQ = 2'd1;
    localparam logic [1:0] MODE_SQ      = 2'd2;

    // Limits and reset values of the coefficient registers.
    localparam logic [COEF_W-1:0] DECAY_MIN   = 17'd655;
    localparam logic [COEF_W-1:0] DECAY_MAX   = 17'd65536;
    localparam logic [COEF_W-1:0] DECAY_RESET = 17'd39322;
    localparam logic [STEP_W-1:0] STEP_MIN    = 13'd66;
    localparam logic [STEP_W-1:0] STEP_MAX    = 13'd6554;
    localparam logic [STEP_W-1:0] STEP_RESET  = 13'd6554;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [1:0]        mode;
        logic [COEF_W-1:0] decay;
        logic [STEP_W-1:0] step_time;
        logic              blocking;
    } dls_cfg_t;

endpackage

// ===== design/dls_cfg.sv =====
module dls_cfg
    import dls_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output dls_cfg_t              cfg
);

    dls_cfg_t cfg_reg;
    dls_cfg_t cfg_next;

    logic [COEF_W-1:0] decay_in;
    logic [STEP_W-1:0] step_in;

    // Registers are always writable.
    assign cfg_ready = 1'b1;

    // Decode a write, saturating the coefficients to their legal ranges.
    always_comb
    begin
        decay_in = cfg_data[COEF_W-1:0];
        step_in  = cfg_data[STEP_W-1:0];
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MODE:
                begin
                    if (cfg_data[1:0] == MODE_HALF_SQ || cfg_data[1:0] == MODE_SQ)
                    begin
                        cfg_next.mode = cfg_data[1:0];
                    end
                    else
                    begin
                        cfg_next.mode = MODE_LINEAR;
                    end
                end
                REG_DECAY:
                begin
                    if (decay_in < DECAY_MIN)
                    begin
                        cfg_next.decay = DECAY_MIN;
                    end
                    else if (decay_in > DECAY_MAX)
                    begin
                        cfg_next.decay = DECAY_MAX;
                    end
                    else
                    begin
                        cfg_next.decay = decay_in;
                    end
                end
                REG_STEP:
                begin
                    if (step_in < STEP_MIN)
                    begin
                        cfg_next.step_time = STEP_MIN;
                    end
                    else if (step_in > STEP_MAX)
                    begin
                        cfg_next.step_time = STEP_MAX;
                    end
                    else
                    begin
                        cfg_next.step_time = step_in;
                    end
                end
                REG_BLOCKING:
                begin
                    cfg_next.blocking = cfg_data[0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode      <= MODE_LINEAR;
            cfg_reg.decay     <= DECAY_RESET;
            cfg_reg.step_time <= STEP_RESET;
            cfg_reg.blocking  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/dls_mul.sv =====
module dls_mul
    import dls_pkg::*;
#(
    parameter int OP_W = DLS_LEVEL_FRAC_BITS + 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [OP_W-1:0]   a,
    input  logic [COEF_W-1:0] b,
    output logic              done,
    output logic [OP_W-1:0]   result
);

    // The wide operand is split in two halves; one narrow multiplier serves both.
    localparam int HALF_W = (OP_W + 1) / 2;
    localparam int PROD_W = HALF_W + COEF_W;
    localparam int SUM_W  = OP_W + COEF_W;

    logic              step_reg;
    logic              step_next;
    logic [PROD_W-1:0] acc_reg;
    logic [HALF_W-1:0] a_part;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  sum;

    // The low half is multiplied first, then the high half.
    always_comb
    begin
        if (step_reg)
        begin
            a_part = HALF_W'(a >> HALF_W);
        end
        else
        begin
            a_part = a[HALF_W-1:0];
        end
        prod = PROD_W'(a_part) * PROD_W'(b);
        sum  = SUM_W'(acc_reg) + (SUM_W'(prod) << HALF_W);
    end

    assign step_next = en ? ~step_reg : 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // Partial product of the low half.
    always_ff @(posedge clk)
    begin
        if (en && !step_reg)
        begin
            acc_reg <= prod;
        end
    end

    // The product is rescaled from Q16 by dropping the fraction bits.
    assign done   = en & step_reg;
    assign result = sum[OP_W+COEF_FRAC-1:COEF_FRAC];

endmodule

// ===== design/damped_level_smoother.sv =====
// An input transfer passes through the multiplier products, S_APPLY and S_SNAP to
// S_FIN and the output register; a force command or a blocked tick goes to S_FIN.
// One item is in work at a time; the next input is taken in the cycle after the
// result is loaded, and an output stall holds an item in S_FIN. The shared
// multiplier serves two products per tick in mode 0 and three in modes 1 and 2.
// Reset clears level, last target, busy flag and sets the registers to defaults.
module damped_level_smoother
    import dls_pkg::*;
#(
    parameter int LEVEL_FRAC_BITS = DLS_LEVEL_FRAC_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  func,
    input  logic [7:0]            data_value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            level_byte,
    output logic [16:0]           level_q16,
    output logic                  busy_res,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int LVL_W = LEVEL_FRAC_BITS + 1;

    localparam logic [LVL_W-1:0] ONE_LEVEL  = LVL_W'(1) << LEVEL_FRAC_BITS;
    localparam logic [LVL_W:0]   ONE_WIDE   = (LVL_W + 1)'(1) << LEVEL_FRAC_BITS;
    localparam logic [LVL_W-1:0] SNAP_LIMIT = LVL_W'(1) << (LEVEL_FRAC_BITS - 12);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_APPLY = 3'd2;
    localparam logic [2:0] S_SNAP  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    localparam logic [1:0] PASS_DECAY  = 2'd0;
    localparam logic [1:0] PASS_STEP   = 2'd1;
    localparam logic [1:0] PASS_DECAY2 = 2'd2;

    dls_cfg_t cfg;

    logic [2:0]       state_reg, state_next;
    logic [1:0]       pass_reg, pass_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic [7:0]       last_target_reg, last_target_next;
    logic             busy_reg, busy_next;
    logic [LVL_W-1:0] target_reg, target_next;
    logic             up_reg, up_next;
    logic [LVL_W-1:0] d_reg, d_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       level_byte_reg;
    logic [16:0]      level_q16_reg;
    logic             busy_res_reg;

    logic [LVL_W-1:0]  target_in;
    logic              in_take;
    logic              out_load;
    logic              run;
    logic              last_pass;
    logic [COEF_W-1:0] coef;
    logic              mul_en;
    logic              mul_done;
    logic [LVL_W-1:0]  mul_result;
    logic [LVL_W:0]    level_up;
    logic [LVL_W-1:0]  gap;
    logic [LVL_W+7:0]  level_x255;

    dls_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dls_mul #(
        .OP_W (LVL_W)
    ) u_mul
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (mul_en),
        .a      (d_reg),
        .b      (coef),
        .done   (mul_done),
        .result (mul_result)
    );

    // Byte divided by 255: the byte repeats in the binary fraction, and 255 is 1.0.
    always_comb
    begin
        target_in = '0;
        for (int i = 0; i < LEVEL_FRAC_BITS; i++)
        begin
            target_in[i] = data_value[7 - ((LEVEL_FRAC_BITS - 1 - i) % 8)];
        end
        if (data_value == 8'hFF)
        begin
            target_in = ONE_LEVEL;
        end
    end

    // Coefficient for the current product.
    always_comb
    begin
        if (pass_reg == PASS_STEP)
        begin
            coef = COEF_W'(cfg.step_time);
        end
        else
        begin
            coef = cfg.decay;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_load  = (state_reg == S_FIN) && (!out_valid_reg || !out_stall);
    assign mul_en    = (state_reg == S_MUL);
    assign run       = !cfg.blocking || (data_value != last_target_reg);
    assign last_pass = (cfg.mode == MODE_LINEAR) ? (pass_reg == PASS_STEP)
                                                 : (pass_reg == PASS_DECAY2);
    assign level_up  = {1'b0, level_reg} + {1'b0, d_reg};
    assign gap       = (target_reg >= level_reg) ? target_reg - level_reg
                                                 : level_reg - target_reg;
    assign level_x255 = {level_reg, 8'h00} - {8'h00, level_reg};

    // Sequencer: accept, products on the shared multiplier, step, snap, hand off.
    always_comb
    begin
        state_next       = state_reg;
        pass_next        = pass_reg;
        level_next       = level_reg;
        last_target_next = last_target_reg;
        busy_next        = busy_reg;
        target_next      = target_reg;
        up_next          = up_reg;
        d_next           = d_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    last_target_next = data_value;
                    target_next      = target_in;
                    up_next          = (target_in >= level_reg);
                    pass_next        = PASS_DECAY;
                    if (target_in >= level_reg)
                    begin
                        d_next = target_in - level_reg;
                    end
                    else
                    begin
                        d_next = level_reg - target_in;
                    end
                    if (func)
                    begin
                        level_next = target_in;
                        busy_next  = 1'b0;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        busy_next  = run;
                        state_next = run ? S_MUL : S_FIN;
                    end
                end
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    if (pass_reg == PASS_DECAY && cfg.mode == MODE_HALF_SQ)
                    begin
                        d_next = mul_result >> 1;
                    end
                    else
                    begin
                        d_next = mul_result;
                    end
                    pass_next = pass_reg + 2'd1;
                    if (last_pass)
                    begin
                        state_next = S_APPLY;
                    end
                end
            end
            S_APPLY:
            begin
                if (up_reg)
                begin
                    if (level_up > ONE_WIDE)
                    begin
                        level_next = ONE_LEVEL;
                        busy_next  = 1'b0;
                    end
                    else
                    begin
                        level_next = level_up[LVL_W-1:0];
                    end
                end
                else
                begin
                    if (d_reg > level_reg)
                    begin
                        level_next = '0;
                        busy_next  = 1'b0;
                    end
                    else
                    begin
                        level_next = level_reg - d_reg;
                    end
                end
                state_next = S_SNAP;
            end
            S_SNAP:
            begin
                if (gap < SNAP_LIMIT)
                begin
                    level_next = target_reg;
                    busy_next  = 1'b0;
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register holds a result until its transfer.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            pass_reg        <= PASS_DECAY;
            level_reg       <= '0;
            last_target_reg <= '0;
            busy_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pass_reg        <= pass_next;
            level_reg       <= level_next;
            last_target_reg <= last_target_next;
            busy_reg        <= busy_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Working values and the result fields.
    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
        up_reg     <= up_next;
        d_reg      <= d_next;
        if (out_load)
        begin
            level_byte_reg <= level_x255[LEVEL_FRAC_BITS+7:LEVEL_FRAC_BITS];
            level_q16_reg  <= level_reg[LEVEL_FRAC_BITS:LEVEL_FRAC_BITS-16];
            busy_res_reg   <= busy_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign level_byte = level_byte_reg;
    assign level_q16  = level_q16_reg;
    assign busy_res   = busy_res_reg;

endmodule

// ===== tb/damped_level_smoother_tb.sv =====
module damped_level_smoother_tb;

    import dls_pkg::*;

    // Command codes of the func field.
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_FORCE = 1'b1;

    localparam int LVL_FRAC      = DLS_LEVEL_FRAC_BITS;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 14;
    localparam int IDLE_PERCENT  = 11;

    typedef struct {
        logic [7:0]  byte_level;
        logic [16:0] q16_level;
        logic        busy;
    } level_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  func = FUNC_TICK;
    logic [7:0]            data_value = 8'd0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [7:0]            level_byte;
    logic [16:0]           level_q16;
    logic                  busy_res;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_MODE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow copy of the smoother: registers and state.
    logic [1:0]        shadow_mode = MODE_LINEAR;
    logic [COEF_W-1:0] shadow_decay = DECAY_RESET;
    logic [STEP_W-1:0] shadow_step = STEP_RESET;
    logic              shadow_blocking = 1'b0;
    logic [30:0]       shadow_level = '0;
    logic [7:0]        shadow_last_byte = 8'd0;

    level_result_t expected_levels[$];

    int  fail_count = 0;
    int  cycle_count = 0;
    int  items_sent = 0;
    int  results_checked = 0;
    int  force_count = 0;
    int  held_count = 0;
    int  snap_count = 0;
    int  settings_written = 0;
    bit  idle_enabled = 1'b1;
    bit  stall_enabled = 1'b1;

    damped_level_smoother dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .data_value (data_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .level_byte (level_byte),
        .level_q16  (level_q16),
        .busy_res   (busy_res),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Advance the shadow level by one item and queue the result it should produce.
    task automatic advance_level(input logic cmd, input logic [7:0] byte_in);
        logic [63:0]   goal;
        logic [63:0]   lvl;
        logic [63:0]   gap;
        logic [63:0]   delta;
        logic [63:0]   full_scale;
        logic          rising;
        logic          moving;
        logic          busy_now;
        level_result_t res;
        full_scale = 64'd1 << LVL_FRAC;
        goal = (64'(byte_in) << LVL_FRAC) / 64'd255;
        lvl = 64'(shadow_level);
        busy_now = 1'b0;
        if (cmd == FUNC_FORCE)
        begin
            lvl = goal;
            force_count++;
        end
        else
        begin
            moving = !shadow_blocking || (byte_in != shadow_last_byte);
            busy_now = moving;
            if (!moving)
                held_count++;
            if (moving)
            begin
                rising = goal >= lvl;
                gap = rising ? goal - lvl : lvl - goal;
                delta = (gap * shadow_decay) >> 16;
                if (shadow_mode == MODE_HALF_SQ)
                    delta = delta >> 1;
                delta = (delta * shadow_step) >> 16;
                if (shadow_mode != MODE_LINEAR)
                    delta = (delta * shadow_decay) >> 16;
                // Move toward the target and saturate at either end of the range.
                if (rising)
                begin
                    lvl = lvl + delta;
                    if (lvl > full_scale)
                    begin
                        lvl = full_scale;
                        busy_now = 1'b0;
                    end
                end
                else if (delta > lvl)
                begin
                    lvl = '0;
                    busy_now = 1'b0;
                end
                else
                begin
                    lvl = lvl - delta;
                end
                // Snap onto the target once the remaining gap is tiny.
                gap = (goal >= lvl) ? goal - lvl : lvl - goal;
                if (gap < (full_scale >> 12))
                begin
                    lvl = goal;
                    busy_now = 1'b0;
                    snap_count++;
                end
            end
        end
        shadow_last_byte = byte_in;
        shadow_level = lvl[30:0];
        res.byte_level = 8'((lvl * 64'd255) >> LVL_FRAC);
        res.q16_level = 17'(lvl >> (LVL_FRAC - 16));
        res.busy = busy_now;
        expected_levels.push_back(res);
    endtask

    // Offer one item, hold it until the transfer, then predict its result.
    task automatic send_item(input logic cmd, input logic [7:0] byte_in);
        if (idle_enabled && ($urandom_range(0, 99) < IDLE_PERCENT))
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= cmd;
        data_value <= byte_in;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        advance_level(cmd, byte_in);
    endtask

    // Stop sending and wait until every queued result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_levels.size() != 0);
    endtask

    // One register transfer; the shadow register clamps as the block does.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        logic [COEF_W-1:0] dec;
        logic [STEP_W-1:0] stp;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        settings_written++;
        case (idx)
            REG_MODE:
                shadow_mode = (value[1:0] > MODE_SQ) ? MODE_LINEAR : value[1:0];
            REG_DECAY:
            begin
                dec = value[COEF_W-1:0];
                if (dec < DECAY_MIN)
                    dec = DECAY_MIN;
                else if (dec > DECAY_MAX)
                    dec = DECAY_MAX;
                shadow_decay = dec;
            end
            REG_STEP:
            begin
                stp = value[STEP_W-1:0];
                if (stp < STEP_MIN)
                    stp = STEP_MIN;
                else if (stp > STEP_MAX)
                    stp = STEP_MAX;
                shadow_step = stp;
            end
            default:
                shadow_blocking = value[0];
        endcase
    endtask

    // Let the block go idle, then write all four registers back to back.
    task automatic program_registers(input logic [1:0] mode_v,
                                     input logic [16:0] decay_v,
                                     input logic [12:0] step_v,
                                     input logic blocking_v);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_register(REG_MODE, 17'(mode_v));
        write_register(REG_DECAY, decay_v);
        write_register(REG_STEP, 17'(step_v));
        write_register(REG_BLOCKING, 17'(blocking_v));
        cfg_valid <= 1'b0;
    endtask

    // Reset defaults: force to both ends, full-scale ticks, and a snap.
    task automatic test_defaults();
        send_item(FUNC_FORCE, 8'd0);
        send_item(FUNC_TICK, 8'd255);
        send_item(FUNC_TICK, 8'd255);
        send_item(FUNC_TICK, 8'd0);
        send_item(FUNC_FORCE, 8'd255);
        send_item(FUNC_TICK, 8'd255);
    endtask

    // Register saturation, mode three, blocking and the slowest and fastest curves.
    task automatic test_register_limits();
        program_registers(2'd3, 17'd0, 13'd0, 1'b1);
        send_item(FUNC_FORCE, 8'd128);
        send_item(FUNC_TICK, 8'd128);
        send_item(FUNC_TICK, 8'd129);
        send_item(FUNC_TICK, 8'd129);
        program_registers(MODE_SQ, 17'h1FFFF, 13'h1FFF, 1'b0);
        send_item(FUNC_TICK, 8'd0);
        send_item(FUNC_TICK, 8'd0);
        send_item(FUNC_FORCE, 8'd1);
        send_item(FUNC_TICK, 8'd0);
        program_registers(MODE_HALF_SQ, 17'd65537, 13'd6555, 1'b0);
        send_item(FUNC_TICK, 8'd255);
        send_item(FUNC_TICK, 8'd255);
        program_registers(MODE_LINEAR, 17'd654, 13'd65, 1'b1);
        send_item(FUNC_TICK, 8'd200);
        send_item(FUNC_TICK, 8'd200);
    endtask

    // Runs of ticks at a held target with the odd force and stray byte, per setting.
    task automatic test_random_phases(input int phases, input int per_phase);
        int          sent;
        int          run;
        logic [7:0]  goal_byte;
        logic [1:0]  mode_v;
        logic [16:0] decay_v;
        logic [12:0] step_v;
        bit          paused;
        for (int p = 0; p < phases; p++)
        begin
            mode_v = 2'($urandom_range(0, 3));
            decay_v = 17'($urandom);
            step_v = 13'($urandom);
            if ($urandom_range(0, 2) == 0)
                decay_v = ($urandom_range(0, 1) != 0) ? DECAY_MAX : DECAY_MIN;
            if ($urandom_range(0, 2) == 0)
                step_v = ($urandom_range(0, 1) != 0) ? STEP_MAX : STEP_MIN;
            if (p == 0)
            begin
                mode_v = MODE_LINEAR;
                decay_v = DECAY_MAX;
                step_v = STEP_MAX;
            end
            else if (p == 1)
            begin
                mode_v = MODE_SQ;
                decay_v = DECAY_MIN;
                step_v = STEP_MIN;
            end
            program_registers(mode_v, decay_v, step_v, 1'($urandom_range(0, 1)));
            // One phase runs with neither side idling.
            idle_enabled = (p != 3);
            stall_enabled = (p != 3);
            sent = 0;
            paused = 1'b0;
            while (sent < per_phase)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_item(FUNC_FORCE, 8'($urandom));
                    sent++;
                end
                else
                begin
                    case ($urandom_range(0, 3))
                        0: goal_byte = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
                        1: goal_byte = shadow_last_byte + 8'($urandom_range(0, 2)) - 8'd1;
                        default: goal_byte = 8'($urandom);
                    endcase
                    run = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 90)
                                                      : $urandom_range(1, 6);
                    for (int k = 0; k < run && sent < per_phase; k++)
                    begin
                        send_item(FUNC_TICK, goal_byte);
                        sent++;
                    end
                end
                if (!paused && sent >= per_phase / 2)
                begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end
        idle_enabled = 1'b1;
        stall_enabled = 1'b1;
    endtask

    // Result checker and random back-pressure on the output channel.
    always @(posedge clk)
    begin
        level_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_levels.size() == 0)
            begin
                $error("unexpected result: level_byte %0d level_q16 %0d busy_res %0d",
                       level_byte, level_q16, busy_res);
                fail_count++;
            end
            else
            begin
                want = expected_levels.pop_front();
                results_checked++;
                if (level_byte !== want.byte_level)
                begin
                    $error("level_byte: expected %0d, got %0d", want.byte_level, level_byte);
                    fail_count++;
                end
                if (level_q16 !== want.q16_level)
                begin
                    $error("level_q16: expected %0d, got %0d", want.q16_level, level_q16);
                    fail_count++;
                end
                if (busy_res !== want.busy)
                begin
                    $error("busy_res: expected %0d, got %0d", want.busy, busy_res);
                    fail_count++;
                end
            end
        end
        out_stall <= stall_enabled && ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    // Watchdog on the whole run.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_register_limits();
        test_random_phases(10, 125);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_levels.size() != 0)
        begin
            $error("%0d results never arrived", expected_levels.size());
            fail_count++;
        end
        $display("Covered %0d items (%0d forces, %0d held ticks, %0d snaps), %0d results checked.",
                 items_sent, force_count, held_count, snap_count, results_checked);
        $display("Register transfers: %0d, including saturated and mode-three values.",
                 settings_written);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
